[hw/rtl/gsof_pkg.sv]
// Shared types and constants for the GSOF frame parser.
// No dependencies; imported by gsof_frame_parser_top.
`default_nettype none

package gsof_pkg;

   // Frame walk states; code 7 is unused and behaves like FS_START
   typedef enum logic [2:0] {
      FS_START  = 3'd0,
      FS_STATUS = 3'd1,
      FS_TYPE   = 3'd2,
      FS_LENGTH = 3'd3,
      FS_DATA   = 3'd4,
      FS_CHECK  = 3'd5,
      FS_END    = 3'd6
   } frame_state_type;

   localparam logic [7:0] START_BYTE   = 8'h02;
   localparam logic [7:0] GSOF_KIND    = 8'h40;
   localparam logic [8:0] FIRST_RECORD = 9'd3;

   localparam int DEFAULT_TYPE_MASK_WIDTH = 64;

endpackage

`default_nettype wire

[hw/rtl/gsof_frame_parser_top.sv]
// GSOF frame parser: byte-stream deframer with checksum and record-type mask.
// Depends on gsof_pkg.
`default_nettype none

// Takes one received byte per request and returns exactly one response per
// byte. Sustained rate is one byte per clock while rsp_tready stays high. A
// byte's response passes from the input register through the frame logic into
// the response register and is valid once that register is loaded. The input
// register keeps accepting while a finished response is still waiting on
// rsp_tready, so one stalled response costs no throughput until both registers
// are full. A response has status 1 only on the checksum byte of a type 0x40
// packet whose additive checksum matches; then types_seen has bit n set for
// each record type n walked in the payload, and high_type_seen flags a type
// at or above TYPE_MASK_WIDTH. Otherwise the whole response is zero. Record
// contents are not decoded.
module gsof_frame_parser_top
   import gsof_pkg::*;
#(
   parameter int TYPE_MASK_WIDTH = DEFAULT_TYPE_MASK_WIDTH,
   localparam int RSP_BITS  = TYPE_MASK_WIDTH + 2,
   localparam int RSP_WIDTH = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire  [7:0]           req_tdata,   // [7:0] rx_byte
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [RSP_WIDTH-1:0] rsp_tdata    // status, types_seen, high_type_seen, zero pad
);

   localparam logic [8:0] MASK_LIMIT = 9'(TYPE_MASK_WIDTH);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // frame state
   frame_state_type            state_ff, state_in;
   logic [7:0]                 nread_ff, nread_in;
   logic [7:0]                 sum_ff, sum_in;
   logic [7:0]                 len_ff, len_in;
   logic [7:0]                 kind_ff, kind_in;
   logic [8:0]                 pos_ff, pos_in;
   logic [TYPE_MASK_WIDTH-1:0] mask_ff, mask_in;
   logic                       ovf_ff, ovf_in;

   // response register
   logic                       out_vld_ff, out_vld_in;
   logic                       out_status_ff, out_status_in;
   logic [TYPE_MASK_WIDTH-1:0] out_mask_ff, out_mask_in;
   logic                       out_hi_ff, out_hi_in;

   logic       take, adv, accept;
   logic [7:0] b, nread_inc, sum_add;
   logic       rec_active, at_type, at_len, type_in_range;

   assign take   = out_vld_ff & rsp_tready;
   assign adv    = in_vld_ff & (~out_vld_ff | take);
   assign req_tready = ~in_vld_ff | adv;
   assign accept = req_tvalid & req_tready;

   assign b         = in_byte_ff;
   assign nread_inc = nread_ff + 8'd1;
   assign sum_add   = sum_ff + b;

   // record header walk over the payload
   assign rec_active    = pos_ff < {1'b0, len_ff};
   assign at_type       = rec_active & ({1'b0, nread_ff} == pos_ff);
   assign at_len        = rec_active & ~at_type & ({1'b0, nread_ff} == pos_ff + 9'd1);
   assign type_in_range = {1'b0, b} < MASK_LIMIT;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (accept) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_tdata;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      nread_in      = nread_ff;
      sum_in        = sum_ff;
      len_in        = len_ff;
      kind_in       = kind_ff;
      pos_in        = pos_ff;
      mask_in       = mask_ff;
      ovf_in        = ovf_ff;
      out_status_in = 1'b0;
      out_mask_in   = '0;
      out_hi_in     = 1'b0;
      if (adv) begin
         unique case (state_ff)
            FS_STATUS: begin
               sum_in   = sum_add;
               state_in = FS_TYPE;
            end
            FS_TYPE: begin
               kind_in  = b;
               sum_in   = sum_add;
               state_in = FS_LENGTH;
            end
            FS_LENGTH: begin
               len_in   = b;
               sum_in   = sum_add;
               state_in = FS_DATA;
            end
            FS_DATA: begin
               if (at_type) begin
                  if (type_in_range) begin
                     for (int i = 0; i < TYPE_MASK_WIDTH; i++) begin
                        mask_in[i] = mask_ff[i] | (b == 8'(i));
                     end
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else if (at_len) begin
                  pos_in = pos_ff + 9'd2 + {1'b0, b};
               end
               nread_in = nread_inc;
               sum_in   = sum_add;
               if (nread_inc >= len_ff) begin
                  state_in = FS_CHECK;
               end
            end
            FS_CHECK: begin
               state_in = FS_END;
               if (b == sum_ff && kind_ff == GSOF_KIND) begin
                  out_status_in = 1'b1;
                  out_mask_in   = mask_ff;
                  out_hi_in     = ovf_ff;
               end
            end
            FS_END: begin
               state_in = FS_START;
            end
            default: begin
               // waiting for start byte; the unused code lands here too
               state_in = FS_START;
               if (b == START_BYTE) begin
                  state_in = FS_STATUS;
                  nread_in = '0;
                  sum_in   = '0;
                  pos_in   = FIRST_RECORD;
                  mask_in  = '0;
                  ovf_in   = 1'b0;
               end
            end
         endcase
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (adv) begin
         out_vld_in = 1'b1;
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= FS_START;
         nread_ff   <= '0;
         sum_ff     <= '0;
         len_ff     <= '0;
         kind_ff    <= '0;
         pos_ff     <= FIRST_RECORD;
         mask_ff    <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         state_ff   <= state_in;
         nread_ff   <= nread_in;
         sum_ff     <= sum_in;
         len_ff     <= len_in;
         kind_ff    <= kind_in;
         pos_ff     <= pos_in;
         mask_ff    <= mask_in;
         ovf_ff     <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      if (adv) begin
         out_status_ff <= out_status_in;
         out_mask_ff   <= out_mask_in;
         out_hi_ff     <= out_hi_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_BITS-1:0] = {out_hi_ff, out_mask_ff, out_status_ff};
   end

`ifndef SYNTHESIS
   // a completed packet response is only held while the frame sits at the end byte
   a_status_ctx: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_status_ff) |-> (state_ff == FS_END && kind_ff == GSOF_KIND))
      else $error("status response outside end-byte context");

   // data count never runs past the length (zero length reads one byte)
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FS_DATA) |-> (nread_ff < len_ff || nread_ff == 8'd0))
      else $error("data byte count beyond payload length");

   // a held input byte does not change or vanish while blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !adv) |=> (in_vld_ff && $stable(in_byte_ff)))
      else $error("input register lost a pending request");
`endif

endmodule

`default_nettype wire
